/* sv/blcb_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the battery level light bar colour breather
// no dependencies

package blcb_pkg;

  localparam int unsigned MV_W     = 14;  // millivolt fields and registers
  localparam int unsigned PERIOD_W = 16;  // fade period register
  localparam int unsigned CFG_W    = 16;  // widest register
  localparam int unsigned CH_W     = 8;   // one colour channel
  localparam int unsigned BLEND_QW = 7;   // 2 segment bits and 5 fraction bits

  localparam logic [MV_W-1:0] SWEEP_START_MV = MV_W'(12400);
  localparam logic [MV_W-1:0] SWEEP_END_MV   = MV_W'(9000);
  localparam logic [MV_W-1:0] SWEEP_STEP_MV  = MV_W'(5);
  localparam int unsigned     TICK_MS        = 10;

  localparam logic [MV_W-1:0]     FLOOR_RST   = MV_W'(10000);
  localparam logic [MV_W-1:0]     CEILING_RST = MV_W'(12000);
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(1000);

  typedef enum logic [1:0] {
    CFG_FLOOR   = 2'd0,
    CFG_CEILING = 2'd1,
    CFG_PERIOD  = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_DARK  = 2'd0,
    MODE_SOLID = 2'd1,
    MODE_FADE  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_CDIV = 6'b000100,
    S_SDIV = 6'b001000,
    S_MUL  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][CH_W-1:0] rgb_t;

  // colour ramp red, orange, yellow, yellow-green, green
  function automatic logic [CH_W-1:0] ramp_chan(input logic [2:0] idx, input logic [1:0] ch);
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    r = 8'd0;
    g = 8'd0;
    unique case (idx)
      3'd0:    begin r = 8'd64; g = 8'd0;  end
      3'd1:    begin r = 8'd64; g = 8'd32; end
      3'd2:    begin r = 8'd64; g = 8'd64; end
      3'd3:    begin r = 8'd32; g = 8'd64; end
      default: begin r = 8'd0;  g = 8'd64; end
    endcase
    unique case (ch)
      2'd0:    ramp_chan = r;
      2'd1:    ramp_chan = g;
      default: ramp_chan = 8'd0;
    endcase
  endfunction

endpackage

/* sv/blcb_div.sv */
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
// dividend bits are shifted in msb first after an initial partial remainder

module blcb_div #(
  parameter int unsigned DvdW = 20,
  parameter int unsigned DivW = 16,
  parameter int unsigned CntW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] rem_init_i,
  input  logic [DvdW-1:0] dvd_i,
  input  logic [CntW-1:0] steps_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quo_o,
  output logic [DivW-1:0] rem_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dsr_q, dsr_d;
  logic [DvdW-1:0] dvd_q, dvd_d;
  logic [DvdW-1:0] quo_q, quo_d;

  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            ge;

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_init_i;
      dsr_d  = divisor_i;
      dvd_d  = dvd_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      quo_d = {quo_q[DvdW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* sv/battery_level_led_colour_breather.sv */
`timescale 1ns / 1ps
// Light bar colour from battery voltage with a breathing fade while charging. A word is
// taken only while the block is idle and gives one result word. A dark word needs no
// divider; a solid colour runs the shared divider when the voltage lies between floor and
// ceiling, and a fade word also runs the same divider for the fade step, then the channel
// multiplier for each channel in turn. A new word is taken only after the last has gone
// to the output register, where a finished word waits while the next is taken. Uses
// blcb_pkg and blcb_div.

module battery_level_led_colour_breather #(
  parameter int unsigned LevelFracBits = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [blcb_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [blcb_pkg::MV_W-1:0]     battery_mv_i,
  input  logic                          stop_active_i,
  input  logic                          stop_led_lit_i,
  input  logic                          charger_attached_i,
  input  logic                          begin_sweep_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [blcb_pkg::CH_W-1:0]     red_o,
  output logic [blcb_pkg::CH_W-1:0]     green_o,
  output logic [blcb_pkg::CH_W-1:0]     blue_o,
  output logic [1:0]                    display_mode_o,
  output logic                          sweep_running_o
);
  import blcb_pkg::*;

  localparam int unsigned LW   = LevelFracBits + 1;
  localparam int unsigned DvdW = LevelFracBits + 4;
  localparam int unsigned CntW = $clog2(DvdW + 1);
  localparam logic [LW-1:0]   LEVEL_ONE     = LW'(1) << LevelFracBits;
  localparam logic [DvdW-1:0] LEVEL_ONE_Q   = DvdW'(1) << LevelFracBits;
  localparam logic [DvdW-1:0] STEP_DIVIDEND = DvdW'(TICK_MS) << LevelFracBits;

  // configuration
  logic [MV_W-1:0]     floor_q, ceil_q;
  logic [PERIOD_W-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= FLOOR_RST;
      ceil_q   <= CEILING_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FLOOR:   floor_q  <= cfg_wdata_i[MV_W-1:0];
        CFG_CEILING: ceil_q   <= cfg_wdata_i[MV_W-1:0];
        CFG_PERIOD:  period_q <= cfg_wdata_i[PERIOD_W-1:0];
        default:     ;
      endcase
    end
  end

  // sequencer and item state
  state_e          state_q, state_d;
  logic [MV_W-1:0] v_q, v_d;
  mode_e           mode_q, mode_d;
  logic            used_q, used_d;
  logic [MV_W-1:0] sweep_mv_q, sweep_mv_d;
  logic            sweep_act_q, sweep_act_d;
  rgb_t            lc_q, lc_d;
  rgb_t            fc_q, fc_d;
  logic [1:0]      chan_q, chan_d;

  // fade state
  logic [LW-1:0]   level_q, level_d;
  logic            rising_q, rising_d;
  logic            armed_q, armed_d;
  rgb_t            latched_q, latched_d;

  // output register
  logic            out_valid_q, out_valid_d;
  rgb_t            out_rgb_q, out_rgb_d;
  mode_e           out_mode_q, out_mode_d;
  logic            out_sweep_q, out_sweep_d;

  // divider hookup
  logic            div_start, div_sel_step, div_done;
  logic [DvdW-1:0] div_quo;
  logic [PERIOD_W-1:0] div_rem;
  logic [PERIOD_W-1:0] div_rem_init, div_divisor;
  logic [DvdW-1:0] div_dvd;
  logic [CntW-1:0] div_steps;

  logic [MV_W-1:0] span, v_off;
  logic            below, above;

  assign span  = ceil_q - floor_q;
  assign v_off = v_q - floor_q;
  assign below = (v_q < floor_q);
  assign above = (v_q >= ceil_q);

  assign div_rem_init = div_sel_step ? '0 : {{(PERIOD_W-MV_W){1'b0}}, v_off};
  assign div_dvd      = div_sel_step ? STEP_DIVIDEND : '0;
  assign div_steps    = div_sel_step ? CntW'(DvdW) : CntW'(BLEND_QW);
  assign div_divisor  = div_sel_step ? period_q : {{(PERIOD_W-MV_W){1'b0}}, span};

  blcb_div #(
    .DvdW (DvdW),
    .DivW (PERIOD_W),
    .CntW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .dvd_i      (div_dvd),
    .steps_i    (div_steps),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // blend inside a segment: quotient of 128*(v-floor)/span holds the segment
  // in its top two bits and 32*n/span below; ramp steps are 0 or 32
  rgb_t blend_rgb;
  always_comb begin
    logic [1:0]      seg;
    logic [4:0]      frac;
    logic            rnz;
    logic [CH_W-1:0] ca, cb;
    seg  = div_quo[BLEND_QW-1:BLEND_QW-2];
    frac = div_quo[BLEND_QW-3:0];
    rnz  = |div_rem;
    for (int i = 0; i < 3; i++) begin
      ca = ramp_chan({1'b0, seg}, 2'(i));
      cb = ramp_chan({1'b0, seg} + 3'd1, 2'(i));
      if (cb > ca) begin
        blend_rgb[i] = ca + {3'b0, frac};
      end else if (cb < ca) begin
        blend_rgb[i] = ca - {3'b0, frac} - {7'b0, rnz};
      end else begin
        blend_rgb[i] = ca;
      end
    end
  end

  rgb_t clamp_rgb;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      clamp_rgb[i] = ramp_chan(below ? 3'd0 : 3'd4, 2'(i));
    end
  end

  // fade step and triangle update
  logic [LW-1:0] step;
  logic [LW-1:0] lvl0, lvl1;
  logic          rise0, rise1;

  always_comb begin
    if (period_q == '0 || div_quo > LEVEL_ONE_Q) begin
      step = LEVEL_ONE;
    end else if (div_quo == '0) begin
      step = LW'(1);
    end else begin
      step = div_quo[LW-1:0];
    end
    lvl0  = armed_q ? level_q : '0;
    rise0 = armed_q ? rising_q : 1'b1;
    if (rise0) begin
      lvl1 = (LEVEL_ONE - lvl0 > step) ? lvl0 + step : LEVEL_ONE;
    end else begin
      lvl1 = (lvl0 > step) ? lvl0 - step : '0;
    end
    if (lvl1 == '0 && !rise0) begin
      rise1 = 1'b1;
    end else if (lvl1 == LEVEL_ONE && rise0) begin
      rise1 = 1'b0;
    end else begin
      rise1 = rise0;
    end
  end

  // one shared channel multiplier
  logic [LW+CH_W-1:0] prod;
  assign prod = {{LW{1'b0}}, latched_q[chan_q]} * {{CH_W{1'b0}}, level_q};

  // sweep and mode at accept
  logic [MV_W-1:0] sweep_base, sweep_next;
  logic            sweep_used;
  assign sweep_base = begin_sweep_i ? SWEEP_START_MV : sweep_mv_q;
  assign sweep_used = begin_sweep_i | sweep_act_q;
  assign sweep_next = (sweep_base > SWEEP_END_MV + SWEEP_STEP_MV) ?
                      sweep_base - SWEEP_STEP_MV : SWEEP_END_MV;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    v_d          = v_q;
    mode_d       = mode_q;
    used_d       = used_q;
    sweep_mv_d   = sweep_mv_q;
    sweep_act_d  = sweep_act_q;
    lc_d         = lc_q;
    fc_d         = fc_q;
    chan_d       = chan_q;
    level_d      = level_q;
    rising_d     = rising_q;
    armed_d      = armed_q;
    latched_d    = latched_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_rgb_d    = out_rgb_q;
    out_mode_d   = out_mode_q;
    out_sweep_d  = out_sweep_q;
    div_start    = 1'b0;
    div_sel_step = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          v_d    = sweep_used ? sweep_base : battery_mv_i;
          used_d = sweep_used;
          if (sweep_used) begin
            sweep_mv_d  = sweep_next;
            sweep_act_d = (sweep_next != SWEEP_END_MV);
          end
          if (stop_active_i && !stop_led_lit_i) begin
            mode_d = MODE_DARK;
          end else if (charger_attached_i && !stop_active_i) begin
            mode_d = MODE_FADE;
          end else begin
            mode_d = MODE_SOLID;
          end
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (mode_q == MODE_DARK) begin
          state_d = S_DONE;
        end else if (!below && !above) begin
          div_start = 1'b1;
          state_d   = S_CDIV;
        end else begin
          lc_d = clamp_rgb;
          if (mode_q == MODE_FADE) begin
            div_start    = 1'b1;
            div_sel_step = 1'b1;
            state_d      = S_SDIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CDIV: begin
        if (div_done) begin
          lc_d = blend_rgb;
          if (mode_q == MODE_FADE) begin
            div_start    = 1'b1;
            div_sel_step = 1'b1;
            state_d      = S_SDIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SDIV: begin
        if (div_done) begin
          latched_d = armed_q ? latched_q : lc_q;
          level_d   = lvl1;
          rising_d  = rise1;
          armed_d   = (lvl1 != '0);
          chan_d    = 2'd0;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        fc_d[chan_q] = prod[LevelFracBits +: CH_W];
        chan_d       = chan_q + 2'd1;
        if (chan_q == 2'd2) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mode_d  = mode_q;
          out_sweep_d = used_q;
          unique case (mode_q)
            MODE_FADE:  out_rgb_d = fc_q;
            MODE_SOLID: out_rgb_d = lc_q;
            default:    out_rgb_d = '0;
          endcase
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sweep_mv_q  <= '0;
      sweep_act_q <= 1'b0;
      level_q     <= '0;
      rising_q    <= 1'b1;
      armed_q     <= 1'b0;
      latched_q   <= '0;
      out_valid_q <= 1'b0;
      chan_q      <= '0;
    end else begin
      state_q     <= state_d;
      sweep_mv_q  <= sweep_mv_d;
      sweep_act_q <= sweep_act_d;
      level_q     <= level_d;
      rising_q    <= rising_d;
      armed_q     <= armed_d;
      latched_q   <= latched_d;
      out_valid_q <= out_valid_d;
      chan_q      <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    mode_q      <= mode_d;
    used_q      <= used_d;
    lc_q        <= lc_d;
    fc_q        <= fc_d;
    out_rgb_q   <= out_rgb_d;
    out_mode_q  <= out_mode_d;
    out_sweep_q <= out_sweep_d;
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign red_o           = out_rgb_q[0];
  assign green_o         = out_rgb_q[1];
  assign blue_o          = out_rgb_q[2];
  assign display_mode_o  = out_mode_q;
  assign sweep_running_o = out_sweep_q;

endmodule

/* sv/blcb_check.sv */
`timescale 1ns / 1ps
// port level checks for battery_level_led_colour_breather
// uses blcb_pkg; bound to the top level below

module blcb_check (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [blcb_pkg::CH_W-1:0]  red_o,
  input logic [blcb_pkg::CH_W-1:0]  green_o,
  input logic [blcb_pkg::CH_W-1:0]  blue_o,
  input logic [1:0]                 display_mode_o,
  input logic                       sweep_running_o
);
  import blcb_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o) && $stable(display_mode_o) && $stable(sweep_running_o))
    else $error("stalled result word changed");

  // one word at a time in the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a word");

  // dark words are black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_mode_o == MODE_DARK |-> red_o == '0 && green_o == '0 && blue_o == '0)
    else $error("dark word is not black");

  // solid colours sit on the ramp: one of red or green at full, no blue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_mode_o == MODE_SOLID |->
      blue_o == '0 && red_o <= 8'd64 && green_o <= 8'd64 && (red_o == 8'd64 || green_o == 8'd64))
    else $error("solid colour off the ramp");

  // fade never exceeds the ramp maximum and has no blue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && display_mode_o == MODE_FADE |->
      blue_o == '0 && red_o <= 8'd64 && green_o <= 8'd64)
    else $error("fade colour out of range");

endmodule

bind battery_level_led_colour_breather blcb_check u_blcb_check (.*);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// testbench for the battery level light bar colour breather: a directed table, then random
// phases over several register settings, checked against table words or a colour predictor
// depends on blcb_pkg and battery_level_led_colour_breather

module tb_top;
  import blcb_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned LEVEL_ONE   = 1 << FRAC_BITS;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_TICKS = 125;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // red, orange, yellow, yellow-green, green
  localparam logic [0:4][0:2][7:0] RAMP_LUT = {
    8'd64, 8'd0,  8'd0,
    8'd64, 8'd32, 8'd0,
    8'd64, 8'd64, 8'd0,
    8'd32, 8'd64, 8'd0,
    8'd0,  8'd64, 8'd0
  };

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic            stop;
    logic            led;
    logic            chg;
    logic            go;
  } tick_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    mode_e      mode;
    logic       sweep;
  } colour_word_t;

  typedef struct {
    logic            is_reg;
    cfg_idx_e        idx;
    logic [CFG_W-1:0] data;
    tick_t           tk;
    logic            typed;
    colour_word_t    want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [MV_W-1:0]     battery_mv_i;
  logic                stop_active_i;
  logic                stop_led_lit_i;
  logic                charger_attached_i;
  logic                begin_sweep_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  logic [CH_W-1:0]     red_o;
  logic [CH_W-1:0]     green_o;
  logic [CH_W-1:0]     blue_o;
  logic [1:0]          display_mode_o;
  logic                sweep_running_o;

  // predictor copy of registers and state
  logic [MV_W-1:0]     floor_mv;
  logic [MV_W-1:0]     ceil_mv;
  logic [PERIOD_W-1:0] period_ms;
  int unsigned         fade_lvl;
  logic                fade_up;
  logic                fade_run;
  rgb_t                held_rgb;
  logic [MV_W-1:0]     sweep_level_mv;
  logic                sweep_on;

  colour_word_t        bar_colour_q [$];
  dir_row_t            dir_tbl [25];
  int unsigned         mismatch_cnt = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         gap_pct = 0;
  int unsigned         stall_pct = 0;

  battery_level_led_colour_breather #(
    .LevelFracBits(FRAC_BITS)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .battery_mv_i       (battery_mv_i),
    .stop_active_i      (stop_active_i),
    .stop_led_lit_i     (stop_led_lit_i),
    .charger_attached_i (charger_attached_i),
    .begin_sweep_i      (begin_sweep_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .red_o              (red_o),
    .green_o            (green_o),
    .blue_o             (blue_o),
    .display_mode_o     (display_mode_o),
    .sweep_running_o    (sweep_running_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i = (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // linear blend between two ramp points, truncated toward minus infinity
  function automatic logic [7:0] mix_chan(input int unsigned a, input int unsigned b,
                                          input int unsigned n, input int unsigned span);
    if (b >= a) return 8'(a + (b - a) * n / span);
    return 8'(a - ((a - b) * n + span - 1) / span);
  endfunction

  function automatic rgb_t gauge_colour(input logic [MV_W-1:0] v);
    rgb_t        c;
    int unsigned span;
    int unsigned t;
    int unsigned k;
    int unsigned n;
    if (v < floor_mv) begin
      for (int i = 0; i < 3; i++) c[i] = RAMP_LUT[0][i];
    end else if (v >= ceil_mv) begin
      for (int i = 0; i < 3; i++) c[i] = RAMP_LUT[4][i];
    end else begin
      span = int'(ceil_mv) - int'(floor_mv);
      t = 4 * (int'(v) - int'(floor_mv));
      k = t / span;
      n = t - k * span;
      if (k > 3) k = 3;
      for (int i = 0; i < 3; i++) c[i] = mix_chan(RAMP_LUT[k][i], RAMP_LUT[k+1][i], n, span);
    end
    return c;
  endfunction

  function automatic int unsigned fade_inc();
    int unsigned s;
    if (period_ms == 0) return LEVEL_ONE;
    s = (TICK_MS << FRAC_BITS) / period_ms;
    if (s == 0) s = 1;
    if (s > LEVEL_ONE) s = LEVEL_ONE;
    return s;
  endfunction

  function automatic colour_word_t predict_bar_colour(input tick_t tk);
    colour_word_t    w;
    rgb_t            lc;
    logic [MV_W-1:0] v;
    logic            on_sweep;
    int unsigned     s;
    w = '0;
    w.mode = MODE_DARK;
    v = tk.mv;
    on_sweep = 1'b0;
    if (tk.go) begin
      sweep_level_mv = SWEEP_START_MV;
      sweep_on = 1'b1;
    end
    if (sweep_on) begin
      v = sweep_level_mv;
      on_sweep = 1'b1;
    end
    if (tk.led || !tk.stop) begin
      lc = gauge_colour(v);
      if (tk.chg && !tk.stop) begin
        s = fade_inc();
        // a new fade cycle latches the current level colour
        if (!fade_run) begin
          held_rgb = lc;
          fade_lvl = 0;
          fade_up = 1'b1;
        end
        if (fade_up) fade_lvl = (LEVEL_ONE - fade_lvl > s) ? fade_lvl + s : LEVEL_ONE;
        else         fade_lvl = (fade_lvl > s) ? fade_lvl - s : 0;
        fade_run = (fade_lvl != 0);
        if (fade_lvl == 0 && !fade_up) fade_up = 1'b1;
        else if (fade_lvl == LEVEL_ONE && fade_up) fade_up = 1'b0;
        w.red   = 8'((int'(held_rgb[0]) * fade_lvl) >> FRAC_BITS);
        w.green = 8'((int'(held_rgb[1]) * fade_lvl) >> FRAC_BITS);
        w.blue  = 8'((int'(held_rgb[2]) * fade_lvl) >> FRAC_BITS);
        w.mode  = MODE_FADE;
      end else begin
        w.red   = lc[0];
        w.green = lc[1];
        w.blue  = lc[2];
        w.mode  = MODE_SOLID;
      end
    end
    if (on_sweep) begin
      sweep_level_mv = (sweep_level_mv > SWEEP_END_MV + SWEEP_STEP_MV) ?
                       sweep_level_mv - SWEEP_STEP_MV : SWEEP_END_MV;
      if (sweep_level_mv == SWEEP_END_MV) sweep_on = 1'b0;
    end
    w.sweep = on_sweep;
    return w;
  endfunction

  function automatic dir_row_t tick_row(input logic [MV_W-1:0] mv, input logic stop,
                                        input logic led, input logic chg, input logic go);
    dir_row_t row;
    row.is_reg = 1'b0;
    row.idx    = CFG_NONE;
    row.data   = '0;
    row.tk     = '{mv, stop, led, chg, go};
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic dir_row_t checked_row(input logic [MV_W-1:0] mv, input logic stop,
                                           input logic led, input logic chg, input logic go,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input mode_e m,
                                           input logic sw);
    dir_row_t row;
    row = tick_row(mv, stop, led, chg, go);
    row.typed = 1'b1;
    row.want  = '{r, g, b, m, sw};
    return row;
  endfunction

  function automatic dir_row_t reg_row(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    dir_row_t row;
    row = tick_row('0, 1'b0, 1'b0, 1'b0, 1'b0);
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    colour_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bar_colour_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected word, expected none actual r=%0d g=%0d b=%0d mode=%0d sw=%0d",
                 $time, red_o, green_o, blue_o, display_mode_o, sweep_running_o);
      end else begin
        want = bar_colour_q.pop_front();
        flag_field("red", want.red, red_o);
        flag_field("green", want.green, green_o);
        flag_field("blue", want.blue, blue_o);
        flag_field("display_mode", 8'(want.mode), 8'(display_mode_o));
        flag_field("sweep_running", 8'(want.sweep), 8'(sweep_running_o));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_tick(input tick_t tk, input logic typed, input colour_word_t want);
    colour_word_t guess;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    battery_mv_i       = tk.mv;
    stop_active_i      = tk.stop;
    stop_led_lit_i     = tk.led;
    charger_attached_i = tk.chg;
    begin_sweep_i      = tk.go;
    in_valid_i         = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    guess = predict_bar_colour(tk);
    bar_colour_q.push_back(typed ? want : guess);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_FLOOR:   floor_mv  = data[MV_W-1:0];
      CFG_CEILING: ceil_mv   = data[MV_W-1:0];
      CFG_PERIOD:  period_ms = data[PERIOD_W-1:0];
      default:     ;
    endcase
  endtask

  task automatic wait_drained();
    while (bar_colour_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    tick_t           tk;
    int unsigned     run_kind;
    int unsigned     run_left;
    int unsigned     f;
    colour_word_t    none;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_NONE;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    battery_mv_i       = '0;
    stop_active_i      = 1'b0;
    stop_led_lit_i     = 1'b0;
    charger_attached_i = 1'b0;
    begin_sweep_i      = 1'b0;
    floor_mv       = FLOOR_RST;
    ceil_mv        = CEILING_RST;
    period_ms      = PERIOD_RST;
    fade_lvl       = 0;
    fade_up        = 1'b1;
    fade_run       = 1'b0;
    held_rgb       = '0;
    sweep_level_mv = '0;
    sweep_on       = 1'b0;
    none     = '0;
    run_left = 0;
    run_kind = 0;

    dir_tbl = '{
      checked_row(14'd0,     0, 0, 0, 0, 8'd64, 8'd0,  8'd0, MODE_SOLID, 1'b0),
      checked_row(14'd16383, 0, 0, 0, 0, 8'd0,  8'd64, 8'd0, MODE_SOLID, 1'b0),
      checked_row(14'd11000, 0, 0, 0, 0, 8'd64, 8'd64, 8'd0, MODE_SOLID, 1'b0),
      checked_row(14'd10500, 0, 0, 0, 0, 8'd64, 8'd32, 8'd0, MODE_SOLID, 1'b0),
      tick_row(14'd11999, 0, 0, 0, 0),
      checked_row(14'd11000, 1, 0, 0, 0, 8'd0,  8'd0,  8'd0, MODE_DARK, 1'b0),
      checked_row(14'd11000, 1, 1, 1, 0, 8'd64, 8'd64, 8'd0, MODE_SOLID, 1'b0),
      tick_row(14'd12000, 0, 0, 1, 0),
      tick_row(14'd0,     0, 1, 1, 0),
      // zero period: full step each tick
      reg_row(CFG_PERIOD, 16'd0),
      tick_row(14'd16383, 0, 0, 1, 0),
      tick_row(14'd11000, 0, 1, 1, 0),
      tick_row(14'd10500, 0, 0, 1, 0),
      // floor equal to ceiling, then floor above ceiling
      reg_row(CFG_FLOOR, 16'd12000),
      checked_row(14'd11999, 0, 0, 0, 0, 8'd64, 8'd0,  8'd0, MODE_SOLID, 1'b0),
      checked_row(14'd12000, 0, 0, 0, 0, 8'd0,  8'd64, 8'd0, MODE_SOLID, 1'b0),
      reg_row(CFG_CEILING, 16'd0),
      checked_row(14'd0,     0, 0, 0, 0, 8'd64, 8'd0,  8'd0, MODE_SOLID, 1'b0),
      checked_row(14'd13000, 0, 0, 0, 0, 8'd0,  8'd64, 8'd0, MODE_SOLID, 1'b0),
      reg_row(CFG_NONE, 16'hffff),
      checked_row(14'd16383, 0, 0, 0, 0, 8'd0,  8'd64, 8'd0, MODE_SOLID, 1'b0),
      // test sweep starts at 12400 mV and overrides the measured voltage
      checked_row(14'd0,     0, 0, 0, 1, 8'd0,  8'd64, 8'd0, MODE_SOLID, 1'b1),
      tick_row(14'd0,     0, 0, 0, 0),
      checked_row(14'd0,     1, 0, 0, 0, 8'd0,  8'd0,  8'd0, MODE_DARK, 1'b1),
      tick_row(14'd5000,  0, 1, 1, 1)
    };

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_reg) begin
        wait_drained();
        write_reg(dir_tbl[i].idx, dir_tbl[i].data);
      end else begin
        push_tick(dir_tbl[i].tk, dir_tbl[i].typed, dir_tbl[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          write_reg(CFG_FLOOR, 16'd10000);
          write_reg(CFG_CEILING, 16'd12000);
          write_reg(CFG_PERIOD, 16'd1000);
        end
        1: begin
          write_reg(CFG_FLOOR, 16'd0);
          write_reg(CFG_CEILING, 16'd16000);
          write_reg(CFG_PERIOD, 16'd10);
        end
        2: begin
          write_reg(CFG_FLOOR, 16'd0);
          write_reg(CFG_CEILING, 16'd16383);
          write_reg(CFG_PERIOD, 16'd65535);
        end
        3: begin
          write_reg(CFG_FLOOR, 16'd16383);
          write_reg(CFG_CEILING, 16'd0);
          write_reg(CFG_PERIOD, 16'd0);
        end
        4: begin
          f = $urandom_range(0, 15000);
          write_reg(CFG_FLOOR, 16'(f));
          write_reg(CFG_CEILING, 16'($urandom_range(f + 1, 16383)));
          write_reg(CFG_PERIOD, 16'($urandom_range(1, 100)));
        end
        5: begin
          write_reg(CFG_FLOOR, 16'd9000);
          write_reg(CFG_CEILING, 16'd12400);
          write_reg(CFG_PERIOD, 16'd20);
        end
        6: begin
          // upper write bits beyond the 14-bit registers are dropped
          write_reg(CFG_FLOOR, 16'($urandom()));
          write_reg(CFG_CEILING, 16'($urandom()));
          write_reg(CFG_PERIOD, 16'($urandom()));
        end
        default: begin
          f = $urandom_range(9000, 12000);
          write_reg(CFG_FLOOR, 16'(f));
          write_reg(CFG_CEILING, 16'(f + 1));
          write_reg(CFG_PERIOD, 16'd1);
        end
      endcase
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // runs of charging ticks let the fade go through whole cycles
        if (run_left == 0) begin
          run_kind = $urandom_range(0, 3);
          run_left = $urandom_range(4, 60);
        end
        run_left--;
        tk.mv = ($urandom_range(0, 3) == 0) ? MV_W'($urandom()) :
                MV_W'($urandom_range(8500, 13000));
        tk.go = ($urandom_range(0, 299) == 0);
        case (run_kind)
          0, 1: begin
            tk.stop = 1'b0;
            tk.chg  = 1'b1;
            tk.led  = 1'($urandom());
          end
          2: begin
            tk.stop = 1'($urandom());
            tk.led  = 1'b1;
            tk.chg  = 1'($urandom());
            if (!tk.stop) tk.chg = 1'b0;
          end
          default: begin
            tk.stop = 1'($urandom());
            tk.led  = 1'($urandom());
            tk.chg  = 1'($urandom());
          end
        endcase
        push_tick(tk, 1'b0, none);
      end
    end

    gap_pct   = 0;
    stall_pct = 0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
